FILE: sv/dccp_pkg.sv
package dccp_pkg;

    localparam int VALUE_WIDTH = 16;

    typedef logic signed [VALUE_WIDTH-1:0] value_t;

    // largest positive value, capped at 32767
    localparam int VALUE_POS_MAX = (2 ** (VALUE_WIDTH - 1)) - 1;
    localparam int MAX_SPEED_DEFAULT = (VALUE_POS_MAX > 32767) ? 32767 : VALUE_POS_MAX;
    localparam value_t MAX_SPEED_RESET = value_t'(MAX_SPEED_DEFAULT);
    localparam value_t DIR_LIMIT = value_t'(80);

    localparam logic [7:0] CHAR_SEMI  = 8'h3B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_S     = 8'h73;
    localparam logic [7:0] CHAR_D     = 8'h64;
    localparam logic [7:0] CHAR_C     = 8'h63;
    localparam logic [7:0] CHAR_B     = 8'h62;
    localparam logic [7:0] CHAR_M     = 8'h6D;
    localparam logic [7:0] CHAR_R     = 8'h72;
    localparam logic [7:0] CHAR_I     = 8'h69;
    localparam logic [7:0] CHAR_O     = 8'h6F;

    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_SPEED = 3'd1,
        CMD_DIR   = 3'd2,
        CMD_SIDE  = 3'd3,
        CMD_MID   = 3'd4,
        CMD_MAX   = 3'd5,
        CMD_STOP  = 3'd6
    } cmd_t;

    typedef struct packed {
        value_t speed;
        value_t dir;
        logic   update;
        logic   backing;
        logic   stop;
        logic   rst_steps;
        logic   ignore;
        value_t side;
        value_t mid;
        value_t max_speed;
    } dccp_result_t;

endpackage

FILE: sv/drive_command_char_parser_top.sv
// Drive command parser. Each input beat carries one received character of a
// command stream of the form letter, optional '-', decimal digits, ';'
// (s speed, d direction, c side threshold, b middle threshold, m max speed),
// plus the immediate letters '/' (stop), 'r' (reset steps), 'i' and 'o'
// (ignore obstacles on/off). Every input beat gives exactly one output beat
// holding the drive settings after that character, with drive_update,
// stop_pulse and reset_steps_pulse as one-beat pulses. The output beat is
// registered and becomes valid in the cycle after input acceptance, and one
// character is taken every cycle: the whole parse step is a single pass of
// logic between the parse state registers and the output register, so
// in_ready stays high as long as the output register is empty or being drained in the same cycle.
module drive_command_char_parser_top
    import dccp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // character channel
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             char_in,
    input  logic                   remote_hold,
    // result channel
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic signed [VALUE_WIDTH-1:0] speed_cmd,
    output logic signed [VALUE_WIDTH-1:0] dir_cmd,
    output logic                   drive_update,
    output logic                   reverse_active,
    output logic                   stop_pulse,
    output logic                   reset_steps_pulse,
    output logic                   obstacle_bypass,
    output logic signed [VALUE_WIDTH-1:0] threshold_side,
    output logic signed [VALUE_WIDTH-1:0] threshold_middle,
    output logic signed [VALUE_WIDTH-1:0] max_speed
);

    dccp_result_t result_next;
    dccp_result_t result_reg;
    logic         out_valid_reg;
    logic         out_valid_next;
    logic         in_beat;

    // a new character may enter whenever the result slot frees up this cycle
    assign in_ready = !out_valid_reg || out_ready;
    assign in_beat  = in_valid && in_ready;

    // parse state and the per-character update
    dccp_core u_core (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (in_beat),
        .char_in         (char_in),
        .remote_hold     (remote_hold),
        .result_next     (result_next)
    );

    // output slot: filled on each input beat, emptied by an output beat
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_beat)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // payload holds while stalled, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_beat)
            result_reg <= result_next;
    end

    assign out_valid         = out_valid_reg;
    assign speed_cmd         = result_reg.speed;
    assign dir_cmd           = result_reg.dir;
    assign drive_update      = result_reg.update;
    assign reverse_active    = result_reg.backing;
    assign stop_pulse        = result_reg.stop;
    assign reset_steps_pulse = result_reg.rst_steps;
    assign obstacle_bypass   = result_reg.ignore;
    assign threshold_side    = result_reg.side;
    assign threshold_middle  = result_reg.mid;
    assign max_speed         = result_reg.max_speed;

endmodule

FILE: sv/dccp_core.sv
module dccp_core
    import dccp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         step,
    input  logic [7:0]   char_in,
    input  logic         remote_hold,
    output dccp_result_t result_next
);

    logic   want_command_reg, want_command_next;
    logic   want_value_reg, want_value_next;
    value_t accum_reg, accum_next;
    logic   negate_reg, negate_next;
    cmd_t   pending_reg, pending_next;
    value_t speed_reg, speed_next;
    value_t dir_reg, dir_next;
    value_t side_reg, side_next;
    value_t mid_reg, mid_next;
    value_t max_speed_reg, max_speed_next;
    logic   ignore_reg, ignore_next;
    logic   backing_reg, backing_next;

    value_t limit;
    value_t clamped;
    value_t signed_val;
    value_t digit_val;
    value_t accum_x10;
    logic   update, stop, rst_steps;

    // clamp from above, then sign, as done on ';'
    always_comb
    begin
        limit      = (pending_reg == CMD_SPEED) ? max_speed_reg : DIR_LIMIT;
        clamped    = (accum_reg > limit) ? limit : accum_reg;
        signed_val = negate_reg ? value_t'(-clamped) : clamped;
        accum_x10  = value_t'((accum_reg <<< 3) + (accum_reg <<< 1));
        digit_val  = value_t'(accum_x10 + value_t'({1'b0, char_in - CHAR_ZERO}));
    end

    always_comb
    begin
        want_command_next = want_command_reg;
        want_value_next   = want_value_reg;
        accum_next        = accum_reg;
        negate_next       = negate_reg;
        pending_next      = pending_reg;
        speed_next        = speed_reg;
        dir_next          = dir_reg;
        side_next         = side_reg;
        mid_next          = mid_reg;
        max_speed_next    = max_speed_reg;
        ignore_next       = ignore_reg;
        backing_next      = backing_reg;
        update            = 1'b0;
        stop              = 1'b0;
        rst_steps         = 1'b0;

        if (char_in == CHAR_SEMI)
        begin
            want_command_next = 1'b1;
            case (pending_reg)
                CMD_SPEED:
                begin
                    accum_next      = signed_val;
                    want_value_next = 1'b0;
                    if (speed_reg != signed_val && !remote_hold)
                    begin
                        speed_next   = signed_val;
                        update       = 1'b1;
                        backing_next = signed_val[VALUE_WIDTH-1];
                    end
                end
                CMD_DIR:
                begin
                    accum_next      = signed_val;
                    want_value_next = 1'b0;
                    if (dir_reg != signed_val && !remote_hold)
                    begin
                        dir_next = signed_val;
                        update   = 1'b1;
                    end
                end
                CMD_SIDE:
                begin
                    side_next       = accum_reg;
                    want_value_next = 1'b0;
                end
                CMD_MID:
                begin
                    mid_next        = accum_reg;
                    want_value_next = 1'b0;
                end
                CMD_MAX:
                begin
                    max_speed_next  = accum_reg;
                    want_value_next = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
        else if (want_command_reg)
        begin
            case (char_in)
                CHAR_SLASH:
                begin
                    pending_next = CMD_STOP;
                    backing_next = 1'b0;
                    speed_next   = '0;
                    stop         = 1'b1;
                end
                CHAR_S, CHAR_D, CHAR_C, CHAR_B, CHAR_M:
                begin
                    want_command_next = 1'b0;
                    want_value_next   = 1'b1;
                    accum_next        = '0;
                    if (char_in == CHAR_S || char_in == CHAR_D)
                        negate_next = 1'b0;
                    case (char_in)
                        CHAR_S:  pending_next = CMD_SPEED;
                        CHAR_D:  pending_next = CMD_DIR;
                        CHAR_C:  pending_next = CMD_SIDE;
                        CHAR_B:  pending_next = CMD_MID;
                        default: pending_next = CMD_MAX;
                    endcase
                end
                CHAR_R:
                begin
                    rst_steps    = 1'b1;
                    pending_next = CMD_NONE;
                end
                CHAR_I:  ignore_next  = 1'b1;
                CHAR_O:  ignore_next  = 1'b0;
                default: pending_next = CMD_NONE;
            endcase
        end
        else if (want_value_reg)
        begin
            if (char_in == CHAR_MINUS)
                negate_next = 1'b1;
            else if (char_in inside {[CHAR_ZERO:CHAR_NINE]})
                accum_next = digit_val;
        end
    end

    always_comb
    begin
        result_next.speed     = speed_next;
        result_next.dir       = dir_next;
        result_next.update    = update;
        result_next.backing   = backing_next;
        result_next.stop      = stop;
        result_next.rst_steps = rst_steps;
        result_next.ignore    = ignore_next;
        result_next.side      = side_next;
        result_next.mid       = mid_next;
        result_next.max_speed = max_speed_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            want_command_reg <= 1'b1;
            want_value_reg   <= 1'b0;
            accum_reg        <= '0;
            negate_reg       <= 1'b0;
            pending_reg      <= CMD_NONE;
            speed_reg        <= '0;
            dir_reg          <= '0;
            side_reg         <= '0;
            mid_reg          <= '0;
            max_speed_reg    <= MAX_SPEED_RESET;
            ignore_reg       <= 1'b0;
            backing_reg      <= 1'b0;
        end
        else if (step)
        begin
            want_command_reg <= want_command_next;
            want_value_reg   <= want_value_next;
            accum_reg        <= accum_next;
            negate_reg       <= negate_next;
            pending_reg      <= pending_next;
            speed_reg        <= speed_next;
            dir_reg          <= dir_next;
            side_reg         <= side_next;
            mid_reg          <= mid_next;
            max_speed_reg    <= max_speed_next;
            ignore_reg       <= ignore_next;
            backing_reg      <= backing_next;
        end
    end

endmodule

FILE: sv/dccp_checker.sv
module dccp_checker
    import dccp_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_ready,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic signed [VALUE_WIDTH-1:0] speed_cmd,
    input logic                   drive_update,
    input logic                   reverse_active,
    input logic                   stop_pulse,
    input logic                   reset_steps_pulse
);

    // a stalled result beat keeps its speed
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(speed_cmd))
        else $error("result changed while stalled");

    // every accepted character gives a result beat on the next cycle
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted character gave no result");

    // backing up always tracks the sign of the stored speed
    a_backing: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> reverse_active == speed_cmd[VALUE_WIDTH-1])
        else $error("reverse_active disagrees with speed sign");

    // a stop clears the speed
    a_stop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && stop_pulse |-> speed_cmd == '0 && !reverse_active)
        else $error("stop left a non-zero speed");

    // one character raises at most one pulse
    a_pulses: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $onehot0({drive_update, stop_pulse, reset_steps_pulse}))
        else $error("more than one pulse in a beat");

endmodule

bind drive_command_char_parser_top dccp_checker u_dccp_checker (.*);

FILE: test/drive_command_char_parser_top_tb.sv
module drive_command_char_parser_top_tb;
    import dccp_pkg::*;

    // keeps its own copy of the parse state and drive settings, works out the
    // settings expected after every accepted character and checks the
    // output beats against them in order
    class command_scoreboard;
        bit     awaiting_letter = 1'b1;
        bit     awaiting_digits = 1'b0;
        value_t accum           = '0;
        bit     negative        = 1'b0;
        cmd_t   pending         = CMD_NONE;
        value_t speed           = '0;
        value_t dir             = '0;
        value_t side            = '0;
        value_t mid             = '0;
        value_t max_spd         = MAX_SPEED_RESET;
        bit     ignore_obs      = 1'b0;
        bit     reversing       = 1'b0;
        int     errors          = 0;

        dccp_result_t settings_due[$];

        task report(string what, value_t got, value_t want);
            errors++;
            $display("mismatch %s: got %0d, want %0d", what, got, want);
        endtask

        task field(string what, value_t got, value_t want);
            if (got !== want)
                report(what, got, want);
        endtask

        function void open_value(cmd_t cmd, bit clear_sign);
            pending         = cmd;
            awaiting_letter = 1'b0;
            awaiting_digits = 1'b1;
            accum           = '0;
            if (clear_sign)
                negative = 1'b0;
        endfunction

        // upper clamp then sign, written back into the accumulator
        function value_t clamp_in_place(value_t limit);
            value_t v;
            v = accum;
            if (v > limit)
                v = limit;
            if (negative)
                v = -v;
            accum = v;
            return v;
        endfunction

        function void predict_char(logic [7:0] ch, logic ovr);
            dccp_result_t r;
            value_t v;
            r.update    = 1'b0;
            r.stop      = 1'b0;
            r.rst_steps = 1'b0;
            if (ch == CHAR_SEMI)
            begin
                // pending command survives, so a second ';' runs it again
                awaiting_letter = 1'b1;
                case (pending)
                    CMD_SPEED:
                    begin
                        v = clamp_in_place(max_spd);
                        if (speed != v && !ovr)
                        begin
                            speed     = v;
                            r.update  = 1'b1;
                            reversing = (v < 0);
                        end
                        awaiting_digits = 1'b0;
                    end
                    CMD_DIR:
                    begin
                        v = clamp_in_place(DIR_LIMIT);
                        if (dir != v && !ovr)
                        begin
                            dir      = v;
                            r.update = 1'b1;
                        end
                        awaiting_digits = 1'b0;
                    end
                    CMD_SIDE:
                    begin
                        side            = accum;
                        awaiting_digits = 1'b0;
                    end
                    CMD_MID:
                    begin
                        mid             = accum;
                        awaiting_digits = 1'b0;
                    end
                    CMD_MAX:
                    begin
                        max_spd         = accum;
                        awaiting_digits = 1'b0;
                    end
                    default: ;
                endcase
            end
            else if (awaiting_letter)
            begin
                case (ch)
                    CHAR_SLASH:
                    begin
                        pending   = CMD_STOP;
                        reversing = 1'b0;
                        speed     = '0;
                        r.stop    = 1'b1;
                    end
                    CHAR_S: open_value(CMD_SPEED, 1'b1);
                    CHAR_D: open_value(CMD_DIR, 1'b1);
                    CHAR_C: open_value(CMD_SIDE, 1'b0);
                    CHAR_B: open_value(CMD_MID, 1'b0);
                    CHAR_M: open_value(CMD_MAX, 1'b0);
                    CHAR_R:
                    begin
                        r.rst_steps = 1'b1;
                        pending     = CMD_NONE;
                    end
                    CHAR_I: ignore_obs = 1'b1;
                    CHAR_O: ignore_obs = 1'b0;
                    default: pending = CMD_NONE;
                endcase
            end
            else if (awaiting_digits)
            begin
                if (ch == CHAR_MINUS)
                    negative = 1'b1;
                else if (ch >= CHAR_ZERO && ch <= CHAR_NINE)
                    accum = accum * value_t'(10) + value_t'(int'(ch) - int'(CHAR_ZERO));
            end
            r.speed     = speed;
            r.dir       = dir;
            r.backing   = reversing;
            r.ignore    = ignore_obs;
            r.side      = side;
            r.mid       = mid;
            r.max_speed = max_spd;
            settings_due.push_back(r);
        endfunction

        task check_settings(dccp_result_t got);
            dccp_result_t want;
            if (settings_due.size() == 0)
            begin
                report("beat with nothing expected", '0, '0);
                return;
            end
            want = settings_due.pop_front();
            field("speed_cmd", got.speed, want.speed);
            field("dir_cmd", got.dir, want.dir);
            field("drive_update", value_t'(got.update), value_t'(want.update));
            field("reverse_active", value_t'(got.backing), value_t'(want.backing));
            field("stop_pulse", value_t'(got.stop), value_t'(want.stop));
            field("reset_steps_pulse", value_t'(got.rst_steps), value_t'(want.rst_steps));
            field("obstacle_bypass", value_t'(got.ignore), value_t'(want.ignore));
            field("threshold_side", got.side, want.side);
            field("threshold_middle", got.mid, want.mid);
            field("max_speed", got.max_speed, want.max_speed);
        endtask
    endclass

    logic                          clk             = 1'b0;
    logic                          rst_n           = 1'b0;
    logic                          in_valid        = 1'b0;
    logic                          in_ready;
    logic [7:0]                    char_in         = 8'h00;
    logic                          remote_hold     = 1'b0;
    logic                          out_valid;
    logic                          out_ready       = 1'b0;
    logic signed [VALUE_WIDTH-1:0] speed_cmd;
    logic signed [VALUE_WIDTH-1:0] dir_cmd;
    logic                          drive_update;
    logic                          reverse_active;
    logic                          stop_pulse;
    logic                          reset_steps_pulse;
    logic                          obstacle_bypass;
    logic signed [VALUE_WIDTH-1:0] threshold_side;
    logic signed [VALUE_WIDTH-1:0] threshold_middle;
    logic signed [VALUE_WIDTH-1:0] max_speed;

    command_scoreboard sb;
    int chars_sent = 0;
    bit tx_steady  = 1'b0;

    drive_command_char_parser_top dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .char_in           (char_in),
        .remote_hold       (remote_hold),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .speed_cmd         (speed_cmd),
        .dir_cmd           (dir_cmd),
        .drive_update      (drive_update),
        .reverse_active    (reverse_active),
        .stop_pulse        (stop_pulse),
        .reset_steps_pulse (reset_steps_pulse),
        .obstacle_bypass   (obstacle_bypass),
        .threshold_side    (threshold_side),
        .threshold_middle  (threshold_middle),
        .max_speed         (max_speed)
    );

    // 4 unit period
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // offer one character beat; the gap before it is drawn here, and valid
    // only drops when there is a gap, so back-to-back beats keep it high
    task automatic send_char(logic [7:0] ch, logic ovr);
        int gap;
        // every so often switch between idling and a gap-free stretch
        if (chars_sent % 80 == 0)
            tx_steady = ($urandom_range(0, 2) == 0);
        gap = tx_steady ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid        <= 1'b1;
        char_in         <= ch;
        remote_hold     <= ovr;
        @(posedge clk);
        // ready is sampled before this edge's register updates land
        while (!in_ready)
            @(posedge clk);
        sb.predict_char(ch, ovr);
        chars_sent++;
    endtask

    task automatic send_text(string s, logic ovr);
        for (int k = 0; k < s.len(); k++)
            send_char(s[k], ovr);
    endtask

    // one random chunk of the stream: mostly well-formed commands with
    // random values, sometimes immediate letters, unknown letters or noise
    task automatic send_random_chunk();
        int     kind;
        int     num;
        string  digits;
        logic   ovr;
        logic [7:0] letter;
        kind = $urandom_range(0, 19);
        ovr  = ($urandom_range(0, 3) == 0);
        if (kind < 12)
        begin
            case ($urandom_range(0, 6))
                0, 1: letter = CHAR_S;
                2, 3: letter = CHAR_D;
                4:    letter = CHAR_C;
                5:    letter = CHAR_B;
                default: letter = CHAR_M;
            endcase
            // value spread: tiny, around the direction clamp, full range,
            // past the wrap, and the edges of the signed range
            case ($urandom_range(0, 5))
                0: num = $urandom_range(0, 9);
                1: num = $urandom_range(0, 120);
                2: num = $urandom_range(0, 65535);
                3: num = $urandom_range(0, 99999);
                4:
                begin
                    case ($urandom_range(0, 4))
                        0: num = 32767;
                        1: num = 32768;
                        2: num = 65535;
                        3: num = 80;
                        default: num = 81;
                    endcase
                end
                default: num = $urandom_range(0, 1000);
            endcase
            digits = $sformatf("%0d", num);
            send_char(letter, 1'($urandom_range(0, 1)));
            if ($urandom_range(0, 2) == 0)
                send_char(CHAR_MINUS, 1'($urandom_range(0, 1)));
            for (int k = 0; k < digits.len(); k++)
            begin
                send_char(digits[k], 1'($urandom_range(0, 1)));
                // a stray character now and then inside the digits
                if ($urandom_range(0, 15) == 0)
                    send_char(8'($urandom_range(8'h3C, 8'hFF)), 1'($urandom_range(0, 1)));
            end
            send_char(CHAR_SEMI, ovr);
            // repeated terminator runs the command again in place
            if ($urandom_range(0, 5) == 0)
                send_char(CHAR_SEMI, 1'($urandom_range(0, 1)));
        end
        else if (kind < 16)
        begin
            case (kind)
                12: letter = CHAR_SLASH;
                13: letter = CHAR_R;
                14: letter = CHAR_I;
                default: letter = CHAR_O;
            endcase
            send_char(letter, ovr);
        end
        else if (kind < 18)
            send_char(8'($urandom_range(8'h61, 8'h7A)), ovr);
        else
        begin
            repeat ($urandom_range(1, 4))
                send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
    endtask

    // result side: random stalls, gap-free stretches, and two long
    // hold-offs so the block fills up and pushes back on the input
    initial
    begin : drain
        int gap;
        int beats;
        bit steady;
        dccp_result_t seen;
        beats  = 0;
        steady = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (beats % 100 == 0)
                steady = ($urandom_range(0, 2) == 0);
            gap = steady ? 0 : $urandom_range(0, 15);
            if (beats == 400 || beats == 1200)
                gap = 300;
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            seen.speed     = speed_cmd;
            seen.dir       = dir_cmd;
            seen.update    = drive_update;
            seen.backing   = reverse_active;
            seen.stop      = stop_pulse;
            seen.rst_steps = reset_steps_pulse;
            seen.ignore    = obstacle_bypass;
            seen.side      = threshold_side;
            seen.mid       = threshold_middle;
            seen.max_speed = max_speed;
            sb.check_settings(seen);
            beats++;
        end
    end

    initial
    begin : stimulus
        sb = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // lower max speed, then a negative speed over the clamp, then the
        // terminator again to flip the sign of the stored accumulator
        send_text("m50;", 1'b0);
        send_text("s-77;;", 1'b0);
        // direction over its clamp, and a threshold that wraps
        send_text("d99;", 1'b0);
        send_text("b99999;", 1'b0);
        // minus accepted but ignored for thresholds
        send_text("c-3;", 1'b0);
        // immediate letters, character extremes, unknown letter
        send_text("/ri", 1'b0);
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b1);
        send_text("oz;", 1'b0);
        // speed blocked by remote hold
        send_text("s5;", 1'b1);

        while (chars_sent < 1750)
            send_random_chunk();
        in_valid <= 1'b0;

        while (sb.settings_due.size() != 0)
            @(posedge clk);
        // keep running a little to catch any stray beat
        repeat (4) @(posedge clk);
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // well beyond the slowest correct run
    initial
    begin : watchdog
        #1600000;
        $display("tb: failure");
        $finish;
    end

endmodule
